@@ sv/lge_pkg.sv @@
// ----------------------------------------------------------------------------
// lge_pkg
// Shared types and constants for the toroidal B3/S23 life grid engine:
// command codes, channel widths, rule counts and the sequencer state type.
// ----------------------------------------------------------------------------
package lge_pkg;

  // Command codes carried in the low bits of the input tdata
  localparam logic [2:0] CMD_CLEAR  = 3'd0;
  localparam logic [2:0] CMD_TOGGLE = 3'd1;
  localparam logic [2:0] CMD_SET    = 3'd2;
  localparam logic [2:0] CMD_STEP   = 3'd3;
  localparam logic [2:0] CMD_READ   = 3'd4;

  // Field widths and packed channel widths
  localparam int CMD_W      = 3;
  localparam int X_W        = 9;
  localparam int Y_W        = 8;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 8;

  // Neighbor counts of the rule
  localparam logic [3:0] BIRTH_COUNT   = 4'd3;
  localparam logic [3:0] SURVIVE_COUNT = 4'd2;

  // Sequencer states
  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_CLR    = 7'b0000010,
    S_ADDR   = 7'b0000100,
    S_RD     = 7'b0001000,
    S_EDIT   = 7'b0010000,
    S_GEN    = 7'b0100000,
    S_GDRAIN = 7'b1000000
  } lge_state_t;

endpackage

@@ sv/life_grid_engine.sv @@
// ----------------------------------------------------------------------------
// life_grid_engine
// Toroidal Game of Life grid (B3/S23), one bit per cell, with a changed-cell
// map. Commands clear, toggle, set, step one generation or read a cell; each
// returns the addressed cell's alive and changed bits.
// ----------------------------------------------------------------------------
//
//  channel  | direction | tdata fields (low bit up)            | width
//  ---------+-----------+--------------------------------------+------
//  in_      | slave     | command[2:0] cell_x[11:3] cell_y[19:12]| 24
//  out_     | master    | cell_alive[0] cell_changed[1]         | 8
//
//  Edits and reads pass through S_ADDR, S_RD and S_EDIT before the result is
//  loaded into the output register. A generation sweep reads one column
//  of three rows per cycle from the current grid bank.
//  Clear zeroes one cell per cycle in both banks and the changed-cell map.
//  After reset a clearing pass runs with in_tready low.
//  A result waiting on out_tready does not block the next transfer in; the
//  sequencer holds at its last step until the output register frees up.
//
module life_grid_engine #(
  parameter int GRID_WIDTH  = 320,
  parameter int GRID_HEIGHT = 240
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // command[2:0], cell_x[11:3], cell_y[19:12], zero fill above
  input  logic [lge_pkg::IN_DATA_W-1:0] in_tdata,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // cell_alive[0], cell_changed[1], zero fill above
  output logic [lge_pkg::OUT_DATA_W-1:0] out_tdata
);
  import lge_pkg::*;

  localparam int CELLS         = GRID_WIDTH * GRID_HEIGHT;
  localparam int CELL_W        = $clog2(CELLS);
  localparam int COL_W         = $clog2(GRID_WIDTH);
  localparam int ROW_W         = $clog2(GRID_HEIGHT);
  localparam int K_W           = $clog2(GRID_WIDTH + 2);
  localparam int K_LAST        = GRID_WIDTH + 1;
  localparam int LAST_ROW_BASE = (GRID_HEIGHT - 1) * GRID_WIDTH;

  // Control and command registers
  lge_state_t         state_r, state_nxt;
  logic [CMD_W-1:0]   cmd_r, cmd_nxt;
  logic [X_W-1:0]     cell_x_r, cell_x_nxt;
  logic [Y_W-1:0]     cell_y_r, cell_y_nxt;
  logic [CELL_W-1:0]  idx_r, idx_nxt;
  logic               inside_r, inside_nxt;
  logic               cur_b_r, cur_b_nxt;
  logic               clr_resp_r, clr_resp_nxt;
  logic [CELL_W-1:0]  clr_cnt_r, clr_cnt_nxt;

  // Generation sweep registers
  logic [K_W-1:0]     gk_r, gk_nxt;
  logic [ROW_W-1:0]   gy_r, gy_nxt;
  logic [CELL_W-1:0]  rb_u_r, rb_u_nxt;
  logic [CELL_W-1:0]  rb_y_r, rb_y_nxt;
  logic [CELL_W-1:0]  rb_d_r, rb_d_nxt;
  logic               p1_v_r, p1_v_nxt;
  logic [CELL_W-1:0]  p1_idx_r;
  logic               p2_v_r;
  logic [CELL_W-1:0]  p2_idx_r;
  logic [2:0]         top_r, mid_r, bot_r;

  // Output register
  logic               out_valid_r, out_valid_nxt;
  logic               out_alive_r, out_alive_nxt;
  logic               out_changed_r, out_changed_nxt;

  // Memory ports
  logic [1:0]         bank_we;
  logic [CELL_W-1:0]  wr_addr;
  logic               wr_data;
  logic               chg_we;
  logic               chg_wdata;
  logic [CELL_W-1:0]  rd_addr [3];
  logic [1:0][2:0]    bank_rd;
  logic               chg_rd_r;

  // Datapath helpers
  logic [COL_W-1:0]   gcol;
  logic [2:0]         cur_col;
  logic [3:0]         ncount;
  logic               gen_val;
  logic               cur_val;
  logic               edit_val;
  logic               edit_wr;
  logic               load_ok;

  // Grid banks: three read copies each, written together
  for (genvar b = 0; b < 2; b++) begin : g_bank
    for (genvar c = 0; c < 3; c++) begin : g_copy
      logic mem [CELLS];
      logic rd_q;
      always_ff @(posedge clk) begin
        if (bank_we[b]) begin
          mem[wr_addr] <= wr_data;
        end
        rd_q <= mem[rd_addr[c]];
      end
      assign bank_rd[b][c] = rd_q;
    end
  end

  // Changed-cell map
  logic chg_mem [CELLS];
  always_ff @(posedge clk) begin
    if (chg_we) begin
      chg_mem[wr_addr] <= chg_wdata;
    end
    chg_rd_r <= chg_mem[idx_r];
  end

  // Column of the current sweep read: wrap left at the start, right at the end
  always_comb begin
    if (gk_r == '0) begin
      gcol = COL_W'(GRID_WIDTH - 1);
    end else if (gk_r == K_W'(K_LAST)) begin
      gcol = '0;
    end else begin
      gcol = COL_W'(gk_r - K_W'(1));
    end
  end

  // Pick the current bank's read column
  assign cur_col = cur_b_r ? bank_rd[1] : bank_rd[0];

  // Apply the rule to the window center
  always_comb begin
    ncount = 4'(top_r[0]) + 4'(top_r[1]) + 4'(top_r[2]) + 4'(mid_r[0]) +
             4'(mid_r[2]) + 4'(bot_r[0]) + 4'(bot_r[1]) + 4'(bot_r[2]);
    gen_val = (ncount == BIRTH_COUNT) || ((ncount == SURVIVE_COUNT) && mid_r[1]);
  end

  // Edit result for the addressed cell
  always_comb begin
    cur_val = cur_col[1];
    case (cmd_r)
      CMD_TOGGLE: edit_val = ~cur_val;
      CMD_SET:    edit_val = 1'b1;
      default:    edit_val = cur_val;
    endcase
    edit_wr = inside_r && ((cmd_r == CMD_TOGGLE) || (cmd_r == CMD_SET));
    load_ok = !out_valid_r || out_tready;
  end

  // Read addresses: rows above, at and below during a sweep, else the cell
  always_comb begin
    if (state_r == S_GEN) begin
      rd_addr[0] = rb_u_r + CELL_W'(gcol);
      rd_addr[1] = rb_y_r + CELL_W'(gcol);
      rd_addr[2] = rb_d_r + CELL_W'(gcol);
    end else begin
      rd_addr[0] = idx_r;
      rd_addr[1] = idx_r;
      rd_addr[2] = idx_r;
    end
  end

  // Write port: clearing pass, sweep write-back or cell edit
  always_comb begin
    bank_we   = 2'b00;
    wr_addr   = idx_r;
    wr_data   = 1'b0;
    chg_we    = 1'b0;
    chg_wdata = 1'b0;
    if (state_r == S_CLR) begin
      bank_we = 2'b11;
      wr_addr = clr_cnt_r;
      chg_we  = 1'b1;
    end else if (p2_v_r) begin
      bank_we   = cur_b_r ? 2'b01 : 2'b10;
      wr_addr   = p2_idx_r;
      wr_data   = gen_val;
      chg_we    = 1'b1;
      chg_wdata = gen_val ^ mid_r[1];
    end else if ((state_r == S_EDIT) && load_ok && edit_wr) begin
      bank_we = 2'b11;
      wr_data = edit_val;
    end
  end

  // Sequencer
  always_comb begin
    state_nxt       = state_r;
    cmd_nxt         = cmd_r;
    cell_x_nxt      = cell_x_r;
    cell_y_nxt      = cell_y_r;
    idx_nxt         = idx_r;
    inside_nxt      = inside_r;
    cur_b_nxt       = cur_b_r;
    clr_resp_nxt    = clr_resp_r;
    clr_cnt_nxt     = clr_cnt_r;
    gk_nxt          = gk_r;
    gy_nxt          = gy_r;
    rb_u_nxt        = rb_u_r;
    rb_y_nxt        = rb_y_r;
    rb_d_nxt        = rb_d_r;
    p1_v_nxt        = 1'b0;
    out_valid_nxt   = out_valid_r && !out_tready;
    out_alive_nxt   = out_alive_r;
    out_changed_nxt = out_changed_r;
    in_tready       = (state_r == S_IDLE);

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd_nxt    = in_tdata[CMD_W-1:0];
          cell_x_nxt = in_tdata[CMD_W+X_W-1:CMD_W];
          cell_y_nxt = in_tdata[CMD_W+X_W+Y_W-1:CMD_W+X_W];
          if (in_tdata[CMD_W-1:0] == CMD_CLEAR) begin
            clr_cnt_nxt  = '0;
            clr_resp_nxt = 1'b1;
            cur_b_nxt    = 1'b0;
            state_nxt    = S_CLR;
          end else begin
            state_nxt = S_ADDR;
          end
        end
      end
      S_CLR: begin
        clr_cnt_nxt = clr_cnt_r + CELL_W'(1);
        if (clr_cnt_r == CELL_W'(CELLS - 1)) begin
          state_nxt = clr_resp_r ? S_ADDR : S_IDLE;
        end
      end
      S_ADDR: begin
        // Linear cell index and range check
        idx_nxt    = CELL_W'(32'(cell_y_r) * 32'(GRID_WIDTH) + 32'(cell_x_r));
        inside_nxt = (32'(cell_x_r) < 32'(GRID_WIDTH)) &&
                     (32'(cell_y_r) < 32'(GRID_HEIGHT));
        if (cmd_r == CMD_STEP) begin
          gk_nxt    = '0;
          gy_nxt    = '0;
          rb_u_nxt  = CELL_W'(LAST_ROW_BASE);
          rb_y_nxt  = '0;
          rb_d_nxt  = CELL_W'(GRID_WIDTH);
          state_nxt = S_GEN;
        end else begin
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        state_nxt = S_EDIT;
      end
      S_EDIT: begin
        if (load_ok) begin
          out_valid_nxt   = 1'b1;
          out_alive_nxt   = inside_r && edit_val;
          out_changed_nxt = inside_r && chg_rd_r;
          state_nxt       = S_IDLE;
        end
      end
      S_GEN: begin
        p1_v_nxt = (gk_r >= K_W'(2));
        if (gk_r == K_W'(K_LAST)) begin
          gk_nxt = '0;
          if (gy_r == ROW_W'(GRID_HEIGHT - 1)) begin
            state_nxt = S_GDRAIN;
          end else begin
            // Advance the three row bases by one row, wrapping at the bottom
            gy_nxt   = gy_r + ROW_W'(1);
            rb_u_nxt = rb_y_r;
            rb_y_nxt = rb_d_r;
            if (gy_r == ROW_W'(GRID_HEIGHT - 2)) begin
              rb_d_nxt = '0;
            end else begin
              rb_d_nxt = rb_d_r + CELL_W'(GRID_WIDTH);
            end
          end
        end else begin
          gk_nxt = gk_r + K_W'(1);
        end
      end
      S_GDRAIN: begin
        // Swap banks once the last write-back has gone out
        if (!p1_v_r && !p2_v_r) begin
          cur_b_nxt = ~cur_b_r;
          state_nxt = S_RD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_cnt_r   <= '0;
      clr_resp_r  <= 1'b0;
      cur_b_r     <= 1'b0;
      p1_v_r      <= 1'b0;
      p2_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      clr_resp_r  <= clr_resp_nxt;
      cur_b_r     <= cur_b_nxt;
      p1_v_r      <= p1_v_nxt;
      p2_v_r      <= p1_v_r;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cmd_r         <= cmd_nxt;
    cell_x_r      <= cell_x_nxt;
    cell_y_r      <= cell_y_nxt;
    idx_r         <= idx_nxt;
    inside_r      <= inside_nxt;
    gk_r          <= gk_nxt;
    gy_r          <= gy_nxt;
    rb_u_r        <= rb_u_nxt;
    rb_y_r        <= rb_y_nxt;
    rb_d_r        <= rb_d_nxt;
    p1_idx_r      <= rb_y_r + CELL_W'(gk_r) - CELL_W'(2);
    p2_idx_r      <= p1_idx_r;
    // Shift the 3x3 window left by one column
    top_r         <= {top_r[1:0], cur_col[0]};
    mid_r         <= {mid_r[1:0], cur_col[1]};
    bot_r         <= {bot_r[1:0], cur_col[2]};
    out_alive_r   <= out_alive_nxt;
    out_changed_r <= out_changed_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_DATA_W - 2)'(0), out_changed_r, out_alive_r};

  // Sweep write-backs only happen while a generation is in flight
  a_wb_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    p2_v_r |-> ((state_r == S_GEN) || (state_r == S_GDRAIN)))
    else $error("write-back outside generation sweep");

  // Column counter never passes the wrapped right column
  a_gk_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_GEN) |-> (gk_r <= K_W'(K_LAST)))
    else $error("sweep column counter out of range");

  // Finishing a command always leaves a result in the output register
  a_result_load: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_EDIT) && load_ok) |=> (out_valid_r && (state_r == S_IDLE)))
    else $error("result not loaded at command finish");

  // No new command is taken during the sweep or clearing pass
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_GEN) || (state_r == S_CLR)) |-> !in_tready)
    else $error("input ready while busy");

endmodule
